>>> rtl/amab_pkg.sv
// shared types and constants of the moving-average filter with bcd display encoder
// no dependencies; imported by amab_digits, accel_moving_average_bcd and the bench

package amab_pkg;

  // default geometry, handed to the top-level parameters
  localparam int WINDOW_LEN_DEF = 16;
  localparam int CHANNELS_DEF   = 4;

  localparam int SAMPLE_W = 16;
  localparam int AVG_W    = 16;
  localparam int CODE_W   = 16;

  // channel codes
  localparam logic [1:0] AXIS_TEMP = 2'd3;

  // display constants
  localparam logic [3:0]        SIGN_NEG  = 4'hA;
  localparam logic [3:0]        SIGN_POS  = 4'hB;
  localparam logic [CODE_W-1:0] TEMP_BASE = 16'hBB00;

  // value / 10000 as a binary fraction: ceil(2^30 / 10000)
  localparam int                   FRAC_W    = 30;
  localparam int                   BCD_MUL_W = 17;
  localparam logic [BCD_MUL_W-1:0] BCD_MUL   = 17'd107375;
  localparam int                   BCD_PROD_W = AVG_W + BCD_MUL_W;

  // two decimal digits peeled off a fraction, plus the remaining fraction
  typedef struct packed {
    logic [3:0]        hi;
    logic [3:0]        lo;
    logic [FRAC_W-1:0] frac;
  } dig_pair_t;

endpackage

>>> rtl/amab_ram.sv
// generic single-write, single-read ram with registered read data (old data on collision)
// no dependencies; used by accel_moving_average_bcd for the sample window

module amab_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/amab_digits.sv
// extracts two decimal digits from a binary fraction by two multiply-by-ten steps
// depends on amab_pkg (dig_pair_t, FRAC_W)

module amab_digits import amab_pkg::*; (
  input  logic [FRAC_W-1:0] frac_in,
  output dig_pair_t         dig_out
);

  logic [FRAC_W+3:0] step_a;
  logic [FRAC_W+3:0] step_b;

  // x * 10 = x * 8 + x * 2, integer part is the next digit
  assign step_a = {1'b0, frac_in, 3'b000} + {3'b000, frac_in, 1'b0};
  assign step_b = {1'b0, step_a[FRAC_W-1:0], 3'b000} + {3'b000, step_a[FRAC_W-1:0], 1'b0};

  assign dig_out.hi   = step_a[FRAC_W+3:FRAC_W];
  assign dig_out.lo   = step_b[FRAC_W+3:FRAC_W];
  assign dig_out.frac = step_b[FRAC_W-1:0];

endmodule

>>> rtl/accel_moving_average_bcd.sv
// top level of the per-channel moving-average filter with bcd display encoder
// depends on amab_pkg, amab_ram and amab_digits
//
// usage
//   in_*  : one request per sample. in_tuser carries the channel (0..2 acceleration
//           axes, 3 temperature), in_tdata the window slot and the raw sample.
//   out_* : one request per accepted sample, in order: the channel's window average
//           and its seven-segment code (sign nibble and three digits for the axes,
//           0xBB00 plus four digits for temperature).
//   throughput : one sample per cycle while no stall holds the pipeline; the sample
//                store is read at acceptance and written as the sample leaves stage 1,
//                with a bypass when the same entry follows.
//   pipeline   : store read / sum update / divide by window / scale by 1/10000 /
//                two digits / two digits and code, then the output register.
//   reset      : synchronous, active low; the per-channel sums and the per-entry
//                valid bits clear at once (an unwritten entry reads as zero), so no
//                clearing pass is needed and in_tready rises right after reset.
//   stall      : when out_tready is low the result stays in the output register;
//                stages ahead of it keep filling until the pipeline is full, and
//                only then does in_tready fall.

module accel_moving_average_bcd import amab_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF,
  parameter int CHANNELS   = CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [3:0] slot, [19:4] sample, [23:20] zero
  input  logic [1:0]  in_tuser,   // [1:0] axis
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [15:0] average, [31:16] display_code
);

  localparam int DEPTH     = CHANNELS * WINDOW_LEN;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int SLOT_W    = $clog2(WINDOW_LEN);
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUM_W     = SAMPLE_W + SLOT_W;
  // compare-and-subtract rounds needed to fold the 4-bit slot and 2-bit axis
  localparam int SLOT_STEPS = 15 / WINDOW_LEN;
  localparam int CH_STEPS   = 3 / CHANNELS;
  // exact division by the window length through a reciprocal
  localparam int DIV_SHIFT  = SUM_W + SLOT_W;
  localparam int DIV_MUL_W  = SUM_W + 1;
  localparam int DIV_PROD_W = SUM_W + DIV_MUL_W;
  localparam logic [63:0] DIV_MUL_FULL =
    ((64'd1 << DIV_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = DIV_MUL_FULL[DIV_MUL_W-1:0];

  // fold the axis onto the channel count
  function automatic logic [CH_W-1:0] chan_of(input logic [1:0] ax);
    logic [3:0] r;
    r = {2'b00, ax};
    for (int i = 0; i < CH_STEPS; i++) begin
      if (r >= 4'(CHANNELS)) begin
        r = r - 4'(CHANNELS);
      end
    end
    return r[CH_W-1:0];
  endfunction

  // fold the slot onto the window length
  function automatic logic [SLOT_W-1:0] slot_of(input logic [3:0] sl);
    logic [6:0] r;
    r = {3'b000, sl};
    for (int i = 0; i < SLOT_STEPS; i++) begin
      if (r >= 7'(WINDOW_LEN)) begin
        r = r - 7'(WINDOW_LEN);
      end
    end
    return r[SLOT_W-1:0];
  endfunction

  // input fields
  logic [1:0]          in_axis;
  logic [3:0]          in_slot;
  logic [SAMPLE_W-1:0] in_sample;

  assign in_axis   = in_tuser;
  assign in_slot   = in_tdata[3:0];
  assign in_sample = in_tdata[19:4];

  // pipeline handshake, ready ripples back from the output register
  logic acc;
  logic out_rdy, s5_rdy, s4_rdy, s3_rdy, s2_rdy, s1_rdy;
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, out_vld_r;

  assign out_rdy   = !out_vld_r || out_tready;
  assign s5_rdy    = !s5_vld_r || out_rdy;
  assign s4_rdy    = !s4_vld_r || s5_rdy;
  assign s3_rdy    = !s3_vld_r || s4_rdy;
  assign s2_rdy    = !s2_vld_r || s3_rdy;
  assign s1_rdy    = !s1_vld_r || s2_rdy;
  assign in_tready = s1_rdy && rst_n;
  assign acc       = in_tvalid && in_tready;

  // store address of the incoming sample
  logic [CH_W-1:0]   rd_ch;
  logic [ADDR_W-1:0] rd_addr;

  assign rd_ch   = chan_of(in_axis);
  assign rd_addr = ADDR_W'(rd_ch) * ADDR_W'(WINDOW_LEN) + ADDR_W'(slot_of(in_slot));

  // stage 1: old sample from the store, running sum update
  logic [1:0]          s1_axis_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic [CH_W-1:0]     s1_ch_r;
  logic [ADDR_W-1:0]   s1_addr_r;
  logic                s1_hit_r;
  logic [SAMPLE_W-1:0] s1_fwd_r;
  logic                s1_old_vld_r;

  logic                wr_en;
  logic                fwd_hit;
  logic [SAMPLE_W-1:0] ram_rd_data;
  logic [SAMPLE_W-1:0] s1_mag;
  logic [SAMPLE_W-1:0] s1_old;
  logic [SUM_W-1:0]    s1_sum_nxt;
  logic                s1_neg;
  logic                s1_is_temp;

  logic [SUM_W-1:0]    sum_r [CHANNELS];
  logic [DEPTH-1:0]    ent_vld_r;

  assign wr_en   = s1_vld_r && s2_rdy;
  // the item leaving stage 1 writes the entry the new item is reading
  assign fwd_hit = wr_en && (s1_addr_r == rd_addr);

  amab_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_window (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (s1_mag),
    .rd_en   (acc),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  assign s1_neg     = s1_sample_r[SAMPLE_W-1];
  assign s1_is_temp = (s1_axis_r == AXIS_TEMP);

  always_comb begin
    // axes keep the magnitude, negation masked to 15 bits
    if (!s1_is_temp && s1_neg) begin
      s1_mag = {1'b0, 15'(~s1_sample_r + 16'd1)};
    end else begin
      s1_mag = s1_sample_r;
    end
    if (s1_hit_r) begin
      s1_old = s1_fwd_r;
    end else if (s1_old_vld_r) begin
      s1_old = ram_rd_data;
    end else begin
      s1_old = '0;
    end
    s1_sum_nxt = sum_r[s1_ch_r] - SUM_W'(s1_old) + SUM_W'(s1_mag);
  end

  // stage 2: divide the sum by the window length
  logic [1:0]            s2_axis_r;
  logic                  s2_neg_r;
  logic [SUM_W-1:0]      s2_sum_r;
  logic [DIV_PROD_W-1:0] div_prod;
  logic [AVG_W-1:0]      s2_avg;

  assign div_prod = DIV_PROD_W'(s2_sum_r) * DIV_PROD_W'(DIV_MUL);
  assign s2_avg   = div_prod[DIV_SHIFT +: AVG_W];

  // stage 3: average / 10000 as a fixed-point fraction, keeps the remainder part
  logic [1:0]            s3_axis_r;
  logic                  s3_neg_r;
  logic [AVG_W-1:0]      s3_avg_r;
  logic [BCD_PROD_W-1:0] bcd_prod;

  assign bcd_prod = BCD_PROD_W'(s3_avg_r) * BCD_PROD_W'(BCD_MUL);

  // stage 4: thousands and hundreds
  logic [1:0]        s4_axis_r;
  logic              s4_neg_r;
  logic [AVG_W-1:0]  s4_avg_r;
  logic [FRAC_W-1:0] s4_frac_r;
  dig_pair_t         dig_hi;

  amab_digits u_dig_hi (
    .frac_in (s4_frac_r),
    .dig_out (dig_hi)
  );

  // stage 5: tens and units, display code
  logic [1:0]        s5_axis_r;
  logic              s5_neg_r;
  logic [AVG_W-1:0]  s5_avg_r;
  logic [3:0]        s5_d3_r;
  logic [3:0]        s5_d2_r;
  logic [FRAC_W-1:0] s5_frac_r;
  dig_pair_t         dig_lo;
  logic [CODE_W-1:0] code_nxt;

  amab_digits u_dig_lo (
    .frac_in (s5_frac_r),
    .dig_out (dig_lo)
  );

  always_comb begin
    if (s5_axis_r == AXIS_TEMP) begin
      code_nxt = TEMP_BASE + {s5_d3_r, s5_d2_r, dig_lo.hi, dig_lo.lo};
    end else begin
      code_nxt = {(s5_neg_r ? SIGN_NEG : SIGN_POS), s5_d3_r, s5_d2_r, dig_lo.hi};
    end
  end

  // output register
  logic [AVG_W-1:0]  out_avg_r;
  logic [CODE_W-1:0] out_code_r;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_code_r, out_avg_r};

  // control state: stage valids, running sums, store entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      ent_vld_r <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        sum_r[c] <= '0;
      end
    end else begin
      if (s1_rdy) begin
        s1_vld_r <= acc;
      end
      if (s2_rdy) begin
        s2_vld_r <= s1_vld_r;
      end
      if (s3_rdy) begin
        s3_vld_r <= s2_vld_r;
      end
      if (s4_rdy) begin
        s4_vld_r <= s3_vld_r;
      end
      if (s5_rdy) begin
        s5_vld_r <= s4_vld_r;
      end
      if (out_rdy) begin
        out_vld_r <= s5_vld_r;
      end
      if (wr_en) begin
        ent_vld_r[s1_addr_r] <= 1'b1;
        sum_r[s1_ch_r]       <= s1_sum_nxt;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_axis_r    <= in_axis;
      s1_sample_r  <= in_sample;
      s1_ch_r      <= rd_ch;
      s1_addr_r    <= rd_addr;
      s1_hit_r     <= fwd_hit;
      s1_fwd_r     <= s1_mag;
      s1_old_vld_r <= ent_vld_r[rd_addr];
    end
    if (s2_rdy) begin
      s2_axis_r <= s1_axis_r;
      s2_neg_r  <= s1_neg;
      s2_sum_r  <= s1_sum_nxt;
    end
    if (s3_rdy) begin
      s3_axis_r <= s2_axis_r;
      s3_neg_r  <= s2_neg_r;
      s3_avg_r  <= s2_avg;
    end
    if (s4_rdy) begin
      s4_axis_r <= s3_axis_r;
      s4_neg_r  <= s3_neg_r;
      s4_avg_r  <= s3_avg_r;
      s4_frac_r <= bcd_prod[FRAC_W-1:0];
    end
    if (s5_rdy) begin
      s5_axis_r <= s4_axis_r;
      s5_neg_r  <= s4_neg_r;
      s5_avg_r  <= s4_avg_r;
      s5_d3_r   <= dig_hi.hi;
      s5_d2_r   <= dig_hi.lo;
      s5_frac_r <= dig_hi.frac;
    end
    if (out_rdy) begin
      out_avg_r  <= s5_avg_r;
      out_code_r <= code_nxt;
    end
  end

  // reciprocal scaling must always yield decimal digits
  a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    s5_vld_r |-> (s5_d3_r <= 4'd9) && (s5_d2_r <= 4'd9) &&
                 (dig_lo.hi <= 4'd9) && (dig_lo.lo <= 4'd9))
    else $error("bcd digit above nine");

  // a stale or wrongly bypassed old sample would make the sum dip below it
  a_sum_covers_old: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> (sum_r[s1_ch_r] >= SUM_W'(s1_old)))
    else $error("running sum smaller than the sample it drops");

  // a result only appears when stage five held an item
  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(s5_vld_r))
    else $error("result raised without a finished item");

endmodule

>>> bench/tb.sv
// self-checking bench for the moving-average filter with bcd display encoder
// depends on amab_pkg and accel_moving_average_bcd; keeps its own copy of the
// window store and channel sums and checks each result request against it

module tb import amab_pkg::*; ();

  // acceleration axes, temperature comes from the package
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam int WIN    = 16;
  localparam int NCHAN  = 4;
  // cycles with no request moving on either side before the run is abandoned
  localparam int WATCHDOG_LIMIT = 5000;
  // settle time after the last result
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [15:0] display_code;
    logic [15:0] average;
  } filt_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // [3:0] slot, [19:4] sample, [23:20] zero
  logic [1:0]  in_tuser   = '0;   // [1:0] axis
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [15:0] average, [31:16] display_code

  // mirror of the block's state
  logic [15:0] window_copy [NCHAN][WIN];
  logic [19:0] sum_copy [NCHAN];

  filt_result_t pending_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int err_count      = 0;
  int n_sent         = 0;
  int n_checked      = 0;
  int quiet_cycles   = 0;

  logic [1:0] last_axis = '0;
  logic [3:0] last_slot = '0;

  accel_moving_average_bcd dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor: magnitude on the axes, window replace, divide by 16, bcd encode
  // ---------------------------------------------------------------------------
  function automatic filt_result_t filter_sample(input logic [1:0] ax, input logic [3:0] sl,
                                                 input logic [15:0] smp);
    logic         neg;
    logic [15:0]  mag;
    logic [15:0]  avg;
    logic [15:0]  bcd;
    int unsigned  rest;
    filt_result_t r;
    neg = smp[15];
    // low 15 bits of the negation, so the most negative sample stores zero
    if (ax != AXIS_TEMP && neg) mag = {1'b0, (~smp[14:0]) + 15'd1};
    else mag = smp;
    sum_copy[ax] = sum_copy[ax] - 20'(window_copy[ax][sl]) + 20'(mag);
    window_copy[ax][sl] = mag;
    avg = sum_copy[ax][19:4];
    // only the low four decimal digits survive
    rest = int'(avg) % 10000;
    for (int k = 0; k < 4; k++) begin
      bcd[k*4 +: 4] = 4'(rest % 10);
      rest = rest / 10;
    end
    r.average = avg;
    if (ax != AXIS_TEMP) r.display_code = {(neg ? SIGN_NEG : SIGN_POS), bcd[15:4]};
    else r.display_code = TEMP_BASE + bcd;   // wraps at 16 bits
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // sender: random idle cycles with noise on the data, then one request
  // valid is only ever lowered by the idle loop, the drain or the end of the run, never right
  // after acceptance, so back-to-back requests keep it high
  // ---------------------------------------------------------------------------
  task automatic send_sample(input logic [1:0] ax, input logic [3:0] sl,
                             input logic [15:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 24'($urandom);
      in_tuser  <= 2'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= ax;
    in_tdata  <= {4'b0000, smp, sl};
    do @(posedge clk); while (!in_tready);
    // accepted at this edge: work out what must come out
    pending_results.push_back(filter_sample(ax, sl, smp));
    last_axis = ax;
    last_slot = sl;
    n_sent++;
  endtask

  // hold the input quiet until every outstanding result has been taken
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls at the rate of the current phase
  // ---------------------------------------------------------------------------
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // result checker, oldest expectation first
  always @(posedge clk) begin : check_result
    filt_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, average", out_tdata[15:0], 16'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[15:0] !== want.average)
          report_mismatch("average", out_tdata[15:0], want.average);
        if (out_tdata[31:16] !== want.display_code)
          report_mismatch("display_code", out_tdata[31:16], want.display_code);
        n_checked++;
      end
    end
  end

  // watchdog: counts cycles in which no request moves on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles, %0d results pending",
                 WATCHDOG_LIMIT, pending_results.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic apply_reset();
    for (int c = 0; c < NCHAN; c++) begin
      sum_copy[c] = '0;
      for (int s = 0; s < WIN; s++) window_copy[c][s] = '0;
    end
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  // field extremes, the most negative sample, averages past 9999, slot reuse
  task automatic test_directed_extremes();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // five full-scale x samples push the average past four digits
    send_sample(AXIS_X, 4'd0,  16'h7FFF);
    send_sample(AXIS_X, 4'd15, 16'h7FFF);
    send_sample(AXIS_X, 4'd1,  16'h7FFF);
    send_sample(AXIS_X, 4'd2,  16'h7FFF);
    send_sample(AXIS_X, 4'd3,  16'h7FFF);
    // most negative sample: magnitude zero but negative sign nibble
    send_sample(AXIS_X, 4'd4,  16'h8000);
    send_sample(AXIS_X, 4'd5,  16'hFFFF);
    send_sample(AXIS_X, 4'd0,  16'h0000);
    send_sample(AXIS_Y, 4'd7,  16'h8001);
    send_sample(AXIS_Y, 4'd8,  16'h0001);
    send_sample(AXIS_Y, 4'd8,  16'h8000);
    send_sample(AXIS_Z, 4'd15, 16'hFFFE);
    send_sample(AXIS_Z, 4'd0,  16'h3039);
    // temperature takes the raw bits unsigned; three full words exceed 9999
    send_sample(AXIS_TEMP, 4'd0,  16'hFFFF);
    send_sample(AXIS_TEMP, 4'd1,  16'hFFFF);
    send_sample(AXIS_TEMP, 4'd2,  16'hFFFF);
    send_sample(AXIS_TEMP, 4'd3,  16'h8000);
    // same entry twice in a row exercises the store bypass
    send_sample(AXIS_TEMP, 4'd2,  16'h1234);
    send_sample(AXIS_TEMP, 4'd2,  16'h0000);
    send_sample(AXIS_TEMP, 4'd15, 16'h0000);
    drain_results();
  endtask

  // random samples with a bias towards extremes and towards the last entry
  task automatic random_phase(input int n_items, input int idle_pct, input int stall_pct);
    logic [1:0]  ax;
    logic [3:0]  sl;
    logic [15:0] smp;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 20) begin
        ax = last_axis;
        sl = last_slot;
      end else begin
        ax = 2'($urandom);
        sl = 4'($urandom);
      end
      if ($urandom_range(99) < 15) begin
        case ($urandom_range(4))
          0:       smp = 16'h8000;
          1:       smp = 16'h7FFF;
          2:       smp = 16'hFFFF;
          3:       smp = 16'h0000;
          default: smp = 16'h0001;
        endcase
      end else begin
        smp = 16'($urandom);
      end
      send_sample(ax, sl, smp);
    end
    // sender holds off until the block has emptied
    drain_results();
  endtask

  task automatic test_back_to_back();
    random_phase(100, 0, 0);
  endtask

  task automatic test_sender_gaps();
    random_phase(100, 85, 0);
  endtask

  task automatic test_receiver_stalls();
    random_phase(100, 0, 85);
  endtask

  task automatic test_mixed_gaps();
    random_phase(100, 32, 32);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    apply_reset();
    test_directed_extremes();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_gaps();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // catch any stray result behind the last one
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d samples on all four channels with and without gaps and stalls",
             n_sent);
    $display("%0d results compared, %0d mismatches", n_checked, err_count);
    if (err_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

>>> accel_moving_average_bcd.f
rtl/amab_pkg.sv
rtl/amab_ram.sv
rtl/amab_digits.sv
rtl/accel_moving_average_bcd.sv
bench/tb.sv
